// ===== rtl/core/ssnf_pkg.sv =====
// Shared constants, types and the segment table for the number frame core.
`timescale 1ns / 1ps

package ssnf_pkg;

    localparam int MAX_DIGITS_DEF = 4;

    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_CTRL  = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // Configuration register indexes
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_DISPLAY_ON = 2'd1;

    // Fixed-point reciprocal of ten, exact for 16-bit dividends
    localparam logic [16:0] RECIP10       = 17'd52429;
    localparam int          RECIP10_SHIFT = 19;

    typedef struct packed {
        logic [2:0] len;
        logic [1:0] pos;
    } frame_hdr_t;

    typedef struct packed {
        logic [2:0] brightness;
        logic       display_on;
    } ctrl_cfg_t;

    function automatic logic [7:0] seg_lookup(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/ssnf_front.sv =====
// Front end: accepts a number and builds its segment bytes, one place per cycle, the last place held while q_full.
`timescale 1ns / 1ps

module ssnf_front #(
    parameter int MAX_DIGITS = ssnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      radix_hex,
    input  logic                      negative,
    input  logic [15:0]               magnitude,
    input  logic [7:0]                dot_mask,
    input  logic                      keep_leading_zeros,
    input  logic [2:0]                digit_count,
    input  logic [1:0]                first_position,
    output logic                      push,
    input  logic                      q_full,
    output ssnf_pkg::frame_hdr_t      push_hdr,
    output logic [MAX_DIGITS*8-1:0]   push_places
);
    import ssnf_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                    busy_reg, busy_next;
    logic [15:0]             m_reg, m_next;
    logic                    hex_reg, neg_reg, neg_next, keep_reg, zb_reg;
    logic [7:0]              dots_reg;
    logic [2:0]              idx_reg, idx_next;
    frame_hdr_t              hdr_reg;
    logic [MAX_DIGITS*8-1:0] places_reg, places_next;

    logic [2:0]  len_clamped;
    logic [32:0] prod;
    logic [15:0] q, q10, rem;
    logic [3:0]  d;
    logic [15:0] m_div;
    logic [7:0]  cur_byte;
    logic        step_go;

    assign in_ready = !busy_reg;

    always_comb begin
        len_clamped = digit_count;
        if (digit_count == 3'd0) begin
            len_clamped = 3'd1;
        end else if (digit_count > 3'(MAX_DIGITS)) begin
            len_clamped = 3'(MAX_DIGITS);
        end
    end

    // Next digit: divide by ten via reciprocal multiply, or nibble split for hex
    always_comb begin
        prod = 33'(m_reg) * 33'(RECIP10);
        q    = 16'(prod[32:RECIP10_SHIFT]);
        q10  = {q[12:0], 3'b000} + {q[14:0], 1'b0};
        rem  = m_reg - q10;
        if (hex_reg) begin
            d     = m_reg[3:0];
            m_div = {4'h0, m_reg[15:4]};
        end else begin
            d     = rem[3:0];
            m_div = q;
        end
    end

    always_comb begin
        neg_next = neg_reg;
        if (zb_reg) begin
            // zero with blanking: single '0' in the rightmost place
            cur_byte = (idx_reg == hdr_reg.len - 3'd1) ? seg_lookup(4'h0) : SEG_BLANK;
        end else begin
            if (m_reg == 16'd0 && !keep_reg) begin
                cur_byte = SEG_BLANK;
            end else begin
                cur_byte = seg_lookup(d);
            end
            if (m_reg == 16'd0 && neg_reg) begin
                cur_byte = SEG_MINUS;
                neg_next = 1'b0;
            end
        end
        cur_byte[7] = cur_byte[7] | dots_reg[3'd7 - idx_reg];
    end

    assign step_go = busy_reg && (idx_reg != 3'd0 || !q_full);
    assign push    = busy_reg && idx_reg == 3'd0 && !q_full;

    always_comb begin
        push_places       = places_reg;
        push_places[7:0]  = cur_byte;
        places_next       = places_reg;
        places_next[8*IDX_W'(idx_reg) +: 8] = cur_byte;
    end
    assign push_hdr = hdr_reg;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            idx_next  = len_clamped - 3'd1;
        end else if (step_go) begin
            if (idx_reg == 3'd0) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            m_reg       <= magnitude;
            hex_reg     <= radix_hex;
            neg_reg     <= negative && !radix_hex;
            keep_reg    <= keep_leading_zeros;
            zb_reg      <= (magnitude == 16'd0) && !keep_leading_zeros;
            dots_reg    <= dot_mask;
            hdr_reg.len <= len_clamped;
            hdr_reg.pos <= first_position;
        end else if (step_go) begin
            m_reg      <= m_div;
            neg_reg    <= neg_next;
            places_reg <= places_next;
        end
    end

endmodule

// ===== rtl/core/ssnf_queue.sv =====
// Two-entry queue between the digit builder and the byte sequencer.
`timescale 1ns / 1ps

module ssnf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ssnf_back.sv =====
// Back end: walks one frame and emits its command and segment words.
`timescale 1ns / 1ps

module ssnf_back #(
    parameter int MAX_DIGITS = ssnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_not_empty,
    input  ssnf_pkg::frame_hdr_t    q_hdr,
    input  logic [MAX_DIGITS*8-1:0] q_places,
    output logic                    pop,
    input  ssnf_pkg::ctrl_cfg_t     cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    out_start,
    output logic                    out_stop,
    output logic                    out_last
);
    import ssnf_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [2:0] k_reg, k_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       start_reg, start_next, stop_reg, stop_next, last_reg, last_next;
    logic       advance, final_word;
    logic [2:0] place_idx;

    assign advance    = !valid_reg || out_ready;
    assign final_word = k_reg == q_hdr.len + 3'd2;
    assign pop        = advance && q_not_empty && final_word;
    assign place_idx  = k_reg - 3'd2;

    always_comb begin
        k_next     = k_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        last_next  = last_reg;
        if (advance) begin
            valid_next = q_not_empty;
            if (q_not_empty) begin
                k_next    = final_word ? 3'd0 : k_reg + 3'd1;
                last_next = final_word;
                if (k_reg == 3'd0) begin
                    byte_next  = CMD_DATA;
                    start_next = 1'b1;
                    stop_next  = 1'b1;
                end else if (k_reg == 3'd1) begin
                    byte_next  = CMD_ADDR | {6'd0, q_hdr.pos};
                    start_next = 1'b1;
                    stop_next  = 1'b0;
                end else if (final_word) begin
                    byte_next  = CMD_CTRL | {4'd0, cfg.display_on, cfg.brightness};
                    start_next = 1'b1;
                    stop_next  = 1'b1;
                end else begin
                    byte_next  = q_places[8*IDX_W'(place_idx) +: 8];
                    start_next = 1'b0;
                    stop_next  = k_reg == q_hdr.len + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        start_reg <= start_next;
        stop_reg  <= stop_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_start = start_reg;
    assign out_stop  = stop_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/core/seven_segment_number_frame_core.sv =====
// Top level of the seven-segment number frame core.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata, s_tuser: one number to show
//  m_       out  m_tvalid/m_tready    m_tdata, m_tuser, m_tlast: frame words
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data: register writes
//
// A number yields 3 + digit_count words, digit_count clamped to 1..MAX_DIGITS,
// one per cycle while m_tready is high. The digit builder takes one divide
// step per place; the word sequencer behind the two-entry queue sets the rate.
// A new number is taken while earlier frames still drain from the queue.
// aresetn is synchronous; it empties the queue and output register and
// clears both configuration registers. cfg_ready is always high.
`timescale 1ns / 1ps

module seven_segment_number_frame_core #(
    parameter int MAX_DIGITS = ssnf_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] magnitude, [23:16] dot_mask, [24] keep_leading_zeros,
    // [27:25] digit_count, [29:28] first_position, [31:30] zero
    input  logic [31:0] s_tdata,
    // [0] radix_hex, [1] negative
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] bus_byte
    output logic [7:0]  m_tdata,
    // [0] start_before, [1] stop_after
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    import ssnf_pkg::*;

    localparam int ENTRY_W = $bits(frame_hdr_t) + MAX_DIGITS * 8;

    ctrl_cfg_t               cfg_reg;
    logic                    push, q_full, pop, q_not_empty;
    frame_hdr_t              push_hdr, head_hdr;
    logic [MAX_DIGITS*8-1:0] push_places, head_places;
    logic [ENTRY_W-1:0]      head_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_BRIGHTNESS) begin
                cfg_reg.brightness <= cfg_data;
            end else if (cfg_index == REG_DISPLAY_ON) begin
                cfg_reg.display_on <= cfg_data[0];
            end
        end
    end

    ssnf_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .radix_hex          (s_tuser[0]),
        .negative           (s_tuser[1]),
        .magnitude          (s_tdata[15:0]),
        .dot_mask           (s_tdata[23:16]),
        .keep_leading_zeros (s_tdata[24]),
        .digit_count        (s_tdata[27:25]),
        .first_position     (s_tdata[29:28]),
        .push               (push),
        .q_full             (q_full),
        .push_hdr           (push_hdr),
        .push_places        (push_places)
    );

    ssnf_queue #(.WIDTH(ENTRY_W)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_hdr, push_places}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_data (head_data)
    );

    assign head_hdr    = head_data[ENTRY_W-1 -: $bits(frame_hdr_t)];
    assign head_places = head_data[MAX_DIGITS*8-1:0];

    ssnf_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_hdr       (head_hdr),
        .q_places    (head_places),
        .pop         (pop),
        .cfg         (cfg_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_start   (m_tuser[0]),
        .out_stop    (m_tuser[1]),
        .out_last    (m_tlast)
    );

    // The control word closes every frame with both marks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[1] && m_tdata[7:6] == 2'b10)
        else $error("frame end word malformed");

    // Address word: start mark, no stop mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && !m_tuser[1] |-> m_tdata[7:2] == 6'b110000)
        else $error("address word malformed");

    // Reset leaves no word pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== verif/seven_segment_number_frame_core_test.sv =====
// Self-checking testbench for the seven-segment number frame core.
`timescale 1ns / 1ps

module seven_segment_number_frame_core_test;
    import ssnf_pkg::*;

    localparam int MAX_PLACES   = ssnf_pkg::MAX_DIGITS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 51;
    localparam int NUM_PHASES   = 5;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] DIGIT_GLYPH [0:15] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    typedef struct {
        logic        hex;
        logic        neg;
        logic [15:0] mag;
        logic [7:0]  dots;
        logic        keep;
        logic [2:0]  count;
        logic [1:0]  pos;
    } number_t;

    typedef struct {
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } frame_word_t;

    // Predicts the frame words of each accepted number and checks them in order.
    class frame_scoreboard;
        frame_word_t expected_words[$];
        int          errors;
        logic [2:0]  brightness;
        logic        display_on;

        function new();
            errors = 0;
            brightness = '0;
            display_on = 1'b0;
        endfunction

        function void set_reg(logic [1:0] index, logic [2:0] data);
            if (index == REG_BRIGHTNESS)
                brightness = data;
            else if (index == REG_DISPLAY_ON)
                display_on = data[0];
        endfunction

        function void add_word(logic [7:0] b, logic st, logic sp, logic fin);
            frame_word_t w;
            w.bus_byte = b;
            w.start_before = st;
            w.stop_after = sp;
            w.last = fin;
            expected_words.push_back(w);
        endfunction

        function void note_number(number_t n);
            int unsigned len;
            int unsigned base;
            int unsigned mag;
            int unsigned d;
            int i;
            logic minus;
            logic [7:0] glyph;
            logic [7:0] places [MAX_PLACES];
            len = n.count;
            if (len < 1)
                len = 1;
            if (len > MAX_PLACES)
                len = MAX_PLACES;
            minus = n.neg && !n.hex;
            base = n.hex ? 16 : 10;
            mag = n.mag;
            for (i = 0; i < MAX_PLACES; i++)
                places[i] = SEG_BLANK;
            if (mag == 0 && !n.keep) begin
                places[len - 1] = DIGIT_GLYPH[0];
            end else begin
                for (i = len; i > 0; i--) begin
                    d = mag % base;
                    glyph = (d == 0 && mag == 0 && !n.keep) ? SEG_BLANK : DIGIT_GLYPH[d];
                    // minus lands on the first place left of the number
                    if (d == 0 && mag == 0 && minus) begin
                        glyph = SEG_MINUS;
                        minus = 1'b0;
                    end
                    places[i - 1] = glyph;
                    mag = mag / base;
                end
            end
            // dot of place i comes from mask bit 7 - i
            for (i = 0; i < len; i++)
                places[i][7] = places[i][7] | n.dots[7 - i];
            add_word(CMD_DATA, 1'b1, 1'b1, 1'b0);
            add_word(CMD_ADDR + 8'(n.pos), 1'b1, 1'b0, 1'b0);
            for (i = 0; i < len; i++)
                add_word(places[i], 1'b0, (i + 1 == len), 1'b0);
            add_word(CMD_CTRL | {4'h0, display_on, brightness}, 1'b1, 1'b1, 1'b1);
        endfunction

        function void check_word(logic [7:0] b, logic st, logic sp, logic fin);
            frame_word_t w;
            if (expected_words.size() == 0) begin
                $error("unexpected word: bus_byte %h", b);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (b !== w.bus_byte) begin
                $error("bus_byte: expected %h, got %h", w.bus_byte, b);
                errors++;
            end
            if (st !== w.start_before) begin
                $error("start_before: expected %b, got %b", w.start_before, st);
                errors++;
            end
            if (sp !== w.stop_after) begin
                $error("stop_after: expected %b, got %b", w.stop_after, sp);
                errors++;
            end
            if (fin !== w.last) begin
                $error("last: expected %b, got %b", w.last, fin);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [2:0]  cfg_data = '0;

    frame_scoreboard board;
    int   cycle_count = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic hold_request = 1'b0;

    seven_segment_number_frame_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic number_t make_number(logic hex, logic neg, logic [15:0] mag,
                                            logic [7:0] dots, logic keep,
                                            logic [2:0] count, logic [1:0] pos);
        number_t n;
        n.hex = hex;
        n.neg = neg;
        n.mag = mag;
        n.dots = dots;
        n.keep = keep;
        n.count = count;
        n.pos = pos;
        return n;
    endfunction

    function automatic number_t random_number();
        number_t n;
        int pick;
        n.hex = 1'($urandom_range(0, 1));
        n.neg = 1'($urandom_range(0, 1));
        n.dots = 8'($urandom);
        n.keep = 1'($urandom_range(0, 1));
        n.pos = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        case (pick)
            0: n.mag = 16'h0000;
            1, 2, 3: n.mag = 16'($urandom_range(0, 99));
            4, 5: n.mag = 16'($urandom_range(0, 9999));
            6: n.mag = 16'($urandom_range(65000, 65535));
            default: n.mag = 16'($urandom);
        endcase
        // mostly legal counts, now and then one outside 1..4
        if ($urandom_range(0, 9) == 0)
            n.count = 3'($urandom_range(0, 7));
        else
            n.count = 3'($urandom_range(1, 4));
        return n;
    endfunction

    task automatic send_number(input number_t n);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, n.pos, n.count, n.keep, n.dots, n.mag};
        s_tuser <= {n.neg, n.hex};
        do @(posedge aclk); while (!s_tready);
        board.note_number(n);
    endtask

    // writes both registers back to back, valid held high between them
    task automatic write_config(input logic [2:0] level, input logic on);
        cfg_valid <= 1'b1;
        cfg_index <= REG_BRIGHTNESS;
        cfg_data <= level;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(REG_BRIGHTNESS, level);
        cfg_index <= REG_DISPLAY_ON;
        cfg_data <= {2'b00, on};
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(REG_DISPLAY_ON, {2'b00, on});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    // result side: random stalls per word, one long hold-off on request
    initial begin
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end
            gap = rx_steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_word(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
        end
    end

    initial begin
        number_t directed[$];
        logic [2:0] levels [NUM_PHASES];
        logic       ons [NUM_PHASES];
        int p;
        int k;
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed numbers at reset configuration
        directed.push_back(make_number(0, 0, 16'd0,     8'h00, 0, 3'd4, 2'd0));
        directed.push_back(make_number(0, 1, 16'd0,     8'h00, 1, 3'd4, 2'd1));
        directed.push_back(make_number(0, 1, 16'd0,     8'h00, 0, 3'd3, 2'd2));
        directed.push_back(make_number(0, 0, 16'd65535, 8'h00, 0, 3'd4, 2'd3));
        directed.push_back(make_number(1, 1, 16'hFFFF,  8'h00, 0, 3'd4, 2'd0));
        directed.push_back(make_number(1, 0, 16'hABCD,  8'hFF, 0, 3'd4, 2'd3));
        directed.push_back(make_number(1, 1, 16'hCDEF,  8'h55, 1, 3'd4, 2'd1));
        directed.push_back(make_number(1, 0, 16'h0123,  8'hAA, 1, 3'd4, 2'd2));
        directed.push_back(make_number(1, 0, 16'h89AB,  8'h00, 0, 3'd4, 2'd0));
        directed.push_back(make_number(0, 1, 16'd42,    8'h00, 0, 3'd4, 2'd0));
        directed.push_back(make_number(0, 1, 16'd42,    8'h00, 1, 3'd4, 2'd0));
        directed.push_back(make_number(0, 1, 16'd9999,  8'h00, 0, 3'd4, 2'd0));
        directed.push_back(make_number(0, 0, 16'd1234,  8'h80, 0, 3'd4, 2'd1));
        directed.push_back(make_number(0, 0, 16'd5678,  8'h40, 0, 3'd4, 2'd2));
        directed.push_back(make_number(0, 0, 16'd9012,  8'h20, 1, 3'd4, 2'd3));
        directed.push_back(make_number(0, 1, 16'd7,     8'h10, 0, 3'd0, 2'd0));
        directed.push_back(make_number(0, 0, 16'd321,   8'h0F, 0, 3'd2, 2'd1));
        directed.push_back(make_number(0, 0, 16'd32768, 8'hFF, 1, 3'd5, 2'd2));
        directed.push_back(make_number(1, 0, 16'h8000,  8'h00, 1, 3'd6, 2'd3));
        directed.push_back(make_number(0, 1, 16'd5,     8'h00, 0, 3'd7, 2'd0));
        directed.push_back(make_number(1, 0, 16'h1234,  8'h00, 1, 3'd2, 2'd2));
        directed.push_back(make_number(0, 0, 16'd0,     8'h80, 1, 3'd1, 2'd3));
        directed.push_back(make_number(0, 1, 16'd6,     8'hC0, 0, 3'd1, 2'd1));
        foreach (directed[i])
            send_number(directed[i]);

        levels[0] = 3'd7; ons[0] = 1'b1;
        levels[1] = 3'd0; ons[1] = 1'b1;
        levels[2] = 3'd7; ons[2] = 1'b0;
        levels[3] = 3'($urandom_range(0, 7)); ons[3] = 1'($urandom_range(0, 1));
        levels[4] = 3'($urandom_range(0, 7)); ons[4] = 1'($urandom_range(0, 1));

        for (p = 0; p < NUM_PHASES; p++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            write_config(levels[p], ons[p]);
            tx_steady = (p == 1 || p == 3);
            rx_steady = (p == 1 || p == 2);
            if (p == 0)
                hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_number(random_number());
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ssnf_pkg.sv
rtl/core/ssnf_front.sv
rtl/core/ssnf_queue.sv
rtl/core/ssnf_back.sv
rtl/core/seven_segment_number_frame_core.sv
verif/seven_segment_number_frame_core_test.sv
